@@ hw/rtl/mkd_pkg.sv @@
// shared types and constants for the multi-key click and long-press detector
package mkd_pkg;

   localparam int NUM_KEYS   = 5;
   localparam int WORD_W     = 16;
   localparam int HOLD_W     = 16;
   localparam int KEY_BIT_W  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_W      = 2;

   localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
   localparam logic [DIV_W-1:0]  DIV_LATCH = 2'd3;

   // input operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLICK      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY0_BIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY4_BIT   = 3'd6;

   localparam logic [HOLD_W-1:0] LONG_PRESS_RST = 16'd2000;
   localparam logic [HOLD_W-1:0] CLICK_RST      = 16'd500;
   localparam logic [KEY_BIT_W-1:0] KEY_BIT_RST [NUM_KEYS] =
      '{5'd12, 5'd11, 5'd16, 5'd15, 5'd4};

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_PRESSED   = 3'd1,
      ST_LONG      = 3'd2,
      ST_LONG_HELD = 3'd3,
      ST_RELEASED  = 3'd4,
      ST_CLICKED   = 3'd5
   } key_state_type;

   typedef struct packed {
      logic [HOLD_W-1:0]                   long_press_ticks;
      logic [HOLD_W-1:0]                   click_ticks;
      logic [NUM_KEYS-1:0][KEY_BIT_W-1:0]  key_bit;
   } cfg_type;

   typedef struct packed {
      logic tick;
      logic scan;
   } step_type;

endpackage

@@ hw/rtl/mkd_req_if.sv @@
// input channel: tick or scan transaction with raw scan word
interface mkd_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] scan_word;

   modport source (output valid, opcode, scan_word, input ready);
   modport sink   (input valid, opcode, scan_word, output ready);
endinterface

@@ hw/rtl/mkd_rsp_if.sv @@
// result channel: per-key event states and sampled levels
interface mkd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] key0_event;
   logic [2:0] key1_event;
   logic [2:0] key2_event;
   logic [2:0] key3_event;
   logic [2:0] key4_event;
   logic [4:0] level_mask;

   modport source (output valid, key0_event, key1_event, key2_event, key3_event,
                   key4_event, level_mask, input ready);
   modport sink   (input valid, key0_event, key1_event, key2_event, key3_event,
                   key4_event, level_mask, output ready);
endinterface

@@ hw/rtl/multi_key_click_long_press_detector.sv @@
// top level: input register, tick divider and scan latch, five key machines
// the input register holds each transaction until the key and rsp valid registers take it
// throughput: one tick or scan transaction per cycle; a stalled result holds the input register
// the key state registers themselves hold the result while rsp is stalled
// reset (synchronous, active high): keys idle and up, latch and divider zero, csr defaults
module multi_key_click_long_press_detector (
   input  logic                            clock,
   input  logic                            reset,
   mkd_req_if.sink                         req,
   mkd_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [mkd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mkd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mkd_pkg::*;

   cfg_type           cfg;
   step_type          step;
   logic              in_valid_ff;
   logic              in_op_ff;
   logic [WORD_W-1:0] in_word_ff;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] latched_ff;
   logic [DIV_W-1:0]  div_ff;
   logic              advance;
   logic              fire;
   key_state_type     key_state [NUM_KEYS];
   logic [NUM_KEYS-1:0] key_level;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;
   assign fire      = in_valid_ff && advance;
   assign step.tick = fire && (in_op_ff == OP_TICK);
   assign step.scan = fire && (in_op_ff == OP_SCAN);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         latched_ff   <= '0;
         div_ff       <= '0;
      end else begin
         if (req.ready) in_valid_ff <= req.valid;
         if (advance) rsp_valid_ff <= in_valid_ff;
         if (step.tick) begin
            // latch on the fourth tick, then every third
            if (div_ff == DIV_LATCH) begin
               latched_ff <= in_word_ff;
               div_ff     <= DIV_W'(1);
            end else begin
               div_ff <= div_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_op_ff   <= req.opcode;
         in_word_ff <= req.scan_word;
      end
   end

   mkd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      mkd_key_unit u_key (
         .clock            (clock),
         .reset            (reset),
         .step             (step),
         .latched_word     (latched_ff),
         .key_bit          (cfg.key_bit[k]),
         .long_press_ticks (cfg.long_press_ticks),
         .click_ticks      (cfg.click_ticks),
         .key_state        (key_state[k]),
         .key_level        (key_level[k])
      );
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.key0_event = key_state[0];
   assign rsp.key1_event = key_state[1];
   assign rsp.key2_event = key_state[2];
   assign rsp.key3_event = key_state[3];
   assign rsp.key4_event = key_state[4];
   assign rsp.level_mask = key_level;

endmodule

@@ hw/rtl/mkd_csr.sv @@
// configuration registers: thresholds and key bit positions
module mkd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mkd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mkd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output mkd_pkg::cfg_type              cfg
);
   import mkd_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks <= LONG_PRESS_RST;
         cfg_ff.click_ticks      <= CLICK_RST;
         for (int k = 0; k < NUM_KEYS; k++) begin
            cfg_ff.key_bit[k] <= KEY_BIT_RST[k];
         end
      end else if (csr_we) begin
         if (csr_index == REG_LONG_PRESS) begin
            cfg_ff.long_press_ticks <= csr_wdata;
         end else if (csr_index == REG_CLICK) begin
            cfg_ff.click_ticks <= csr_wdata;
         end else if (csr_index >= REG_KEY0_BIT && csr_index <= REG_KEY4_BIT) begin
            cfg_ff.key_bit[csr_index - REG_KEY0_BIT] <= csr_wdata[KEY_BIT_W-1:0];
         end
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/mkd_key_unit.sv @@
// one key's event machine, level and press-time counter
module mkd_key_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  mkd_pkg::step_type           step,
   input  logic [mkd_pkg::WORD_W-1:0]  latched_word,
   input  logic [mkd_pkg::KEY_BIT_W-1:0] key_bit,
   input  logic [mkd_pkg::HOLD_W-1:0]  long_press_ticks,
   input  logic [mkd_pkg::HOLD_W-1:0]  click_ticks,
   output mkd_pkg::key_state_type      key_state,
   output logic                        key_level
);
   import mkd_pkg::*;

   key_state_type     state_ff, state_in;
   logic              level_ff, level_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic              now;
   logic [3:0]        bit_idx;

   // positions 1..16 select a bit, anything else reads as down
   assign bit_idx = key_bit[3:0] - 4'd1;
   assign now = (key_bit != '0) && (key_bit <= KEY_BIT_W'(WORD_W)) ?
                latched_word[bit_idx] : 1'b0;

   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      hold_in  = hold_ff;
      if (step.tick) begin
         if (state_ff == ST_PRESSED && hold_ff != HOLD_MAX) begin
            hold_in = hold_ff + 1'b1;
         end
      end else if (step.scan) begin
         level_in = now;
         case (state_ff)
            ST_LONG: begin
               hold_in  = '0;
               state_in = ST_LONG_HELD;
            end
            ST_LONG_HELD: begin
               if (now) state_in = ST_RELEASED;
            end
            default: begin
               if (!now) begin
                  if (level_ff) begin
                     state_in = ST_PRESSED;
                     hold_in  = '0;
                  end else if (hold_ff > long_press_ticks) begin
                     state_in = ST_LONG;
                  end
               end else if (!level_ff) begin
                  state_in = (hold_ff < click_ticks) ? ST_CLICKED : ST_RELEASED;
               end else begin
                  hold_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= 1'b1;
         hold_ff  <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         hold_ff  <= hold_in;
      end
   end

   assign key_state = state_ff;
   assign key_level = level_ff;

   a_long_to_held: assert property (@(posedge clock) disable iff (reset)
      step.scan && state_ff == ST_LONG |=> state_ff == ST_LONG_HELD && hold_ff == '0)
      else $error("long press did not move to long held");

   a_tick_keeps_state: assert property (@(posedge clock) disable iff (reset)
      step.tick |=> $stable(state_ff) && $stable(level_ff))
      else $error("tick changed key state or level");

   a_hold_only_pressed: assert property (@(posedge clock) disable iff (reset)
      step.tick && state_ff != ST_PRESSED |=> $stable(hold_ff))
      else $error("press time counted outside pressed state");

endmodule
